FILE: rtl/hsvc_pkg.sv
// Shared constants, codes and stage types for the RGB/HSV color converter.
package hsvc_pkg;

    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_FRAC_BITS = 16;

    localparam int PIX_W  = 8;
    localparam int HUE_W  = 15;
    localparam int UNIT_W = UNIT_FRAC_BITS + 1;
    localparam int SEC_W  = 12;

    localparam logic [UNIT_W-1:0] UNIT_ONE    = UNIT_W'(1 << UNIT_FRAC_BITS);
    localparam logic [SEC_W-1:0]  SECTOR      = SEC_W'(60 << HUE_FRAC_BITS);
    localparam logic [SEC_W-1:0]  HALF_SECTOR = SEC_W'(30 << HUE_FRAC_BITS);
    localparam logic [15:0]       TURN        = 16'(6 * (60 << HUE_FRAC_BITS));

    // Divider: 24-bit dividend, 8-bit divisor, four quotient bits per stage.
    localparam int DIV_NUM_W  = 24;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;

    // floor(z / 15) = (z * RECIP15) >> RECIP_SHIFT, exact for z below 2^20.
    localparam logic [19:0] RECIP15     = 20'd559241;
    localparam int          RECIP_SHIFT = 23;

    localparam int PIPE_STAGES = DIV_STAGES + 2;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_INV = 1'b1;

    localparam logic REG_DIRECTION = 1'b0;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic                 dir;
        logic [1:0]           sect;
        logic                 neg;
        logic                 no_hue;
        logic                 sat_zero;
        logic [UNIT_W-1:0]    val_q;
        logic [DIV_NUM_W-1:0] sat_num;
        logic [DIV_NUM_W-1:0] hue_num;
        logic [PIX_W-1:0]     mx;
        logic [PIX_W-1:0]     d;
        logic [UNIT_W-1:0]    s;
        logic [UNIT_W-1:0]    v;
        logic [SEC_W-1:0]     x;
        logic [2:0]           sec;
        logic                 grey;
    } t_front;

    typedef struct packed {
        logic              dir;
        logic [1:0]        sect;
        logic              neg;
        logic              no_hue;
        logic              sat_zero;
        logic [UNIT_W-1:0] val;
    } t_side;

endpackage

FILE: rtl/hsvc_in_if.sv
// Input channel carrying one pixel beat for either conversion direction.
interface hsvc_in_if;
    logic                              valid;
    logic                              ready;
    logic [hsvc_pkg::PIX_W-1:0]        red_in;
    logic [hsvc_pkg::PIX_W-1:0]        green_in;
    logic [hsvc_pkg::PIX_W-1:0]        blue_in;
    logic [hsvc_pkg::HUE_W-1:0]        hue_in;
    logic [hsvc_pkg::UNIT_W-1:0]       sat_in;
    logic [hsvc_pkg::UNIT_W-1:0]       val_in;
    logic                              no_hue_in;

    modport source (output valid, red_in, green_in, blue_in, hue_in, sat_in, val_in,
                    no_hue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, hue_in, sat_in, val_in,
                  no_hue_in, output ready);
endinterface

FILE: rtl/hsvc_out_if.sv
// Output channel carrying one converted pixel beat.
interface hsvc_out_if;
    logic                              valid;
    logic                              ready;
    logic [hsvc_pkg::HUE_W-1:0]        hue_out;
    logic [hsvc_pkg::UNIT_W-1:0]       sat_out;
    logic [hsvc_pkg::UNIT_W-1:0]       val_out;
    logic                              no_hue_out;
    logic [hsvc_pkg::PIX_W-1:0]        red_out;
    logic [hsvc_pkg::PIX_W-1:0]        green_out;
    logic [hsvc_pkg::PIX_W-1:0]        blue_out;

    modport source (output valid, hue_out, sat_out, val_out, no_hue_out, red_out,
                    green_out, blue_out, input ready);
    modport sink (input valid, hue_out, sat_out, val_out, no_hue_out, red_out,
                  green_out, blue_out, output ready);
endinterface

FILE: rtl/hsvc_front.sv
// First pipeline stage: max/min, sector pick and dividends, hue reduction and clamps.
module hsvc_front (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  logic                        i_dir,
    input  logic [hsvc_pkg::PIX_W-1:0]  i_red,
    input  logic [hsvc_pkg::PIX_W-1:0]  i_green,
    input  logic [hsvc_pkg::PIX_W-1:0]  i_blue,
    input  logic [hsvc_pkg::HUE_W-1:0]  i_hue,
    input  logic [hsvc_pkg::UNIT_W-1:0] i_sat,
    input  logic [hsvc_pkg::UNIT_W-1:0] i_val,
    input  logic                        i_no_hue,
    output hsvc_pkg::t_front            o_front
);
    import hsvc_pkg::*;

    t_front           n_front;
    t_front           r_front;
    logic [PIX_W-1:0] mx, mn, a, b, mag;
    logic [15:0]      h;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;

        n_front     = '0;
        n_front.dir = i_dir;
        n_front.mx  = mx;
        n_front.d   = mx - mn;

        if (i_red == mx) begin
            n_front.sect = SECT_RED;
            a = i_green;
            b = i_blue;
        end else if (i_green == mx) begin
            n_front.sect = SECT_GREEN;
            a = i_blue;
            b = i_red;
        end else begin
            n_front.sect = SECT_BLUE;
            a = i_red;
            b = i_green;
        end
        n_front.neg      = a < b;
        mag              = (a < b) ? (b - a) : (a - b);
        n_front.no_hue   = (n_front.d == '0);
        n_front.sat_zero = (n_front.d == '0);
        n_front.hue_num  = DIV_NUM_W'(mag) * DIV_NUM_W'(SECTOR) + DIV_NUM_W'(n_front.d >> 1);
        n_front.sat_num  = {n_front.d, 16'd0} + DIV_NUM_W'(mx >> 1);
        // Since max*65536 is max*255*257 plus max, the rounded value is max*257,
        // plus one when max is 128 or more.
        n_front.val_q    = UNIT_W'({mx, mx}) + UNIT_W'(mx[PIX_W-1]);

        // Inverse side: one subtract covers any 15-bit hue past a full turn.
        h = (16'(i_hue) >= TURN) ? (16'(i_hue) - TURN) : 16'(i_hue);
        n_front.s    = (i_sat > UNIT_ONE) ? UNIT_ONE : i_sat;
        n_front.v    = (i_val > UNIT_ONE) ? UNIT_ONE : i_val;
        n_front.grey = i_no_hue || (n_front.s == '0);
        if (h >= 16'(5 * SECTOR)) begin
            n_front.sec = 3'd5;
            n_front.x   = SEC_W'(h - 16'(5 * SECTOR));
        end else if (h >= 16'(4 * SECTOR)) begin
            n_front.sec = 3'd4;
            n_front.x   = SEC_W'(h - 16'(4 * SECTOR));
        end else if (h >= 16'(3 * SECTOR)) begin
            n_front.sec = 3'd3;
            n_front.x   = SEC_W'(h - 16'(3 * SECTOR));
        end else if (h >= 16'(2 * SECTOR)) begin
            n_front.sec = 3'd2;
            n_front.x   = SEC_W'(h - 16'(2 * SECTOR));
        end else if (h >= 16'(SECTOR)) begin
            n_front.sec = 3'd1;
            n_front.x   = SEC_W'(h - 16'(SECTOR));
        end else begin
            n_front.sec = 3'd0;
            n_front.x   = SEC_W'(h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

FILE: rtl/hsvc_div_pipe.sv
// Pipelined restoring divider, 24-bit dividend by 8-bit divisor, four bits per stage.
module hsvc_div_pipe (
    input  logic                                i_clk,
    input  logic [hsvc_pkg::DIV_STAGES-1:0]     i_adv,
    input  logic [hsvc_pkg::DIV_NUM_W-1:0]      i_num,
    input  logic [hsvc_pkg::PIX_W-1:0]          i_den,
    output logic [hsvc_pkg::DIV_NUM_W-1:0]      o_quo
);
    import hsvc_pkg::*;

    logic [DIV_NUM_W-1:0] s_num [0:DIV_STAGES];
    logic [DIV_NUM_W-1:0] s_quo [0:DIV_STAGES];
    logic [PIX_W-1:0]     s_rem [0:DIV_STAGES];
    logic [PIX_W-1:0]     s_den [0:DIV_STAGES];

    assign s_num[0] = i_num;
    assign s_quo[0] = '0;
    assign s_rem[0] = '0;
    assign s_den[0] = i_den;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_NUM_W-1:0] n_num, n_quo, r_num, r_quo;
        logic [PIX_W-1:0]     n_rem, r_rem, r_den;

        always_comb begin
            logic [PIX_W:0] t;
            n_num = s_num[k];
            n_quo = s_quo[k];
            n_rem = s_rem[k];
            for (int j = 0; j < DIV_STEP; j++) begin
                t     = {n_rem, n_num[DIV_NUM_W-1]};
                n_num = n_num << 1;
                if (t >= {1'b0, s_den[k]}) begin
                    n_rem = PIX_W'(t - {1'b0, s_den[k]});
                    n_quo = {n_quo[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = t[PIX_W-1:0];
                    n_quo = {n_quo[DIV_NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_num <= n_num;
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_den <= s_den[k];
            end
        end

        assign s_num[k+1] = r_num;
        assign s_quo[k+1] = r_quo;
        assign s_rem[k+1] = r_rem;
        assign s_den[k+1] = r_den;
    end

    assign o_quo = s_quo[DIV_STAGES];

endmodule

FILE: rtl/hsvc_inv_pipe.sv
// HSV to RGB datapath: sector factors, channel products and rounding over six stages.
module hsvc_inv_pipe (
    input  logic                              i_clk,
    input  logic [hsvc_pkg::DIV_STAGES-1:0]   i_adv,
    input  logic [hsvc_pkg::UNIT_W-1:0]       i_s,
    input  logic [hsvc_pkg::UNIT_W-1:0]       i_v,
    input  logic [hsvc_pkg::SEC_W-1:0]       i_x,
    input  logic [2:0]                        i_sec,
    input  logic                              i_grey,
    output logic [hsvc_pkg::PIX_W-1:0]        o_red,
    output logic [hsvc_pkg::PIX_W-1:0]        o_green,
    output logic [hsvc_pkg::PIX_W-1:0]        o_blue
);
    import hsvc_pkg::*;

    // Stage A: s*x and s*(S-x) with rounding bias.
    logic [28:0]       r_px, r_pt;
    logic [UNIT_W-1:0] r_a_p, r_a_v;
    logic [2:0]        r_a_sec;
    logic              r_a_grey;
    // Stage B: divide by 256 then by 15 through the reciprocal.
    logic [39:0]       r_mq, r_mt;
    logic [UNIT_W-1:0] r_b_p, r_b_v;
    logic [2:0]        r_b_sec;
    logic              r_b_grey;
    // Stage C: channel weights.
    logic [UNIT_W-1:0] n_wr, n_wg, n_wb, r_wr, r_wg, r_wb, r_c_v;
    logic [UNIT_W-1:0] q, t;
    // Stage D: v times weight.
    logic [33:0]       r_mr, r_mg, r_mb;
    // Stage E and F: scale by 255/2^32, round, clamp.
    logic [PIX_W-1:0]  n_cr, n_cg, n_cb, r_er, r_eg, r_eb, r_fr, r_fg, r_fb;

    function automatic logic [PIX_W-1:0] scale8(input logic [33:0] m);
        logic [41:0] y;
        y = ({8'd0, m} << 8) - {8'd0, m} + 42'(64'd1 << 31);
        return (y[41:32] > 10'd255) ? 8'd255 : y[39:32];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_px     <= 29'(i_s) * 29'(i_x) + 29'(HALF_SECTOR);
            r_pt     <= 29'(i_s) * 29'(SECTOR - i_x) + 29'(HALF_SECTOR);
            r_a_p    <= UNIT_ONE - i_s;
            r_a_v    <= i_v;
            r_a_sec  <= i_sec;
            r_a_grey <= i_grey;
        end
        if (i_adv[1]) begin
            r_mq     <= 40'(r_px[28:8]) * 40'(RECIP15);
            r_mt     <= 40'(r_pt[28:8]) * 40'(RECIP15);
            r_b_p    <= r_a_p;
            r_b_v    <= r_a_v;
            r_b_sec  <= r_a_sec;
            r_b_grey <= r_a_grey;
        end
    end

    always_comb begin
        q = UNIT_ONE - r_mq[RECIP_SHIFT+UNIT_W-1:RECIP_SHIFT];
        t = UNIT_ONE - r_mt[RECIP_SHIFT+UNIT_W-1:RECIP_SHIFT];
        case (r_b_sec)
            3'd0: begin n_wr = UNIT_ONE; n_wg = t;        n_wb = r_b_p;    end
            3'd1: begin n_wr = q;        n_wg = UNIT_ONE; n_wb = r_b_p;    end
            3'd2: begin n_wr = r_b_p;    n_wg = UNIT_ONE; n_wb = t;        end
            3'd3: begin n_wr = r_b_p;    n_wg = q;        n_wb = UNIT_ONE; end
            3'd4: begin n_wr = t;        n_wg = r_b_p;    n_wb = UNIT_ONE; end
            default: begin n_wr = UNIT_ONE; n_wg = r_b_p; n_wb = q;        end
        endcase
        if (r_b_grey) begin
            n_wr = UNIT_ONE;
            n_wg = UNIT_ONE;
            n_wb = UNIT_ONE;
        end
        n_cr = scale8(r_mr);
        n_cg = scale8(r_mg);
        n_cb = scale8(r_mb);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r_wr  <= n_wr;
            r_wg  <= n_wg;
            r_wb  <= n_wb;
            r_c_v <= r_b_v;
        end
        if (i_adv[3]) begin
            r_mr <= 34'(r_c_v) * 34'(r_wr);
            r_mg <= 34'(r_c_v) * 34'(r_wg);
            r_mb <= 34'(r_c_v) * 34'(r_wb);
        end
        if (i_adv[4]) begin
            r_er <= n_cr;
            r_eg <= n_cg;
            r_eb <= n_cb;
        end
        if (i_adv[5]) begin
            r_fr <= r_er;
            r_fg <= r_eg;
            r_fb <= r_eb;
        end
    end

    assign o_red   = r_fr;
    assign o_green = r_fg;
    assign o_blue  = r_fb;

endmodule

FILE: rtl/rgb_hsv_color_convert_unit.sv
// Top level of the pipelined RGB to HSV and HSV to RGB pixel converter.
// This block converts one pixel per beat in either direction, chosen by the direction
// register at byte address 0 of the APB port (0: RGB to HSV, 1: HSV to RGB; write it only
// while no pixel is in flight). It takes a new pixel every clock unless the output stalls
// with every stage full, and each result passes through eight register
// stages: one stage for max/min, sector decode and the value, six stages of the
// pipelined divider that forms saturation and hue (four quotient bits per stage), and
// the output register. The inverse path runs beside the divider over the same six
// stages. Every stage advances on its own when the next one is free, so a stall at the
// output squeezes out bubbles and the input stays ready whenever the output register is
// empty. Hue is in 1/64-degree units, saturation and value use 65536 for 1.0, and unused
// result fields read zero.
module rgb_hsv_color_convert_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvc_in_if.sink     i_pix,
    hsvc_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hsvc_pkg::*;

    logic                       r_dir;
    logic [PIPE_STAGES:1]       r_vld;
    logic [PIPE_STAGES:1]       adv;
    t_front                     front;
    t_side                      r_side [0:DIV_STAGES-1];
    logic [DIV_NUM_W-1:0]       q_sat, q_hue;
    logic [PIX_W-1:0]           inv_r, inv_g, inv_b;
    logic [15:0]                base, tmp;
    t_side                      side;

    // Configuration: single direction register, read back when paddr[2] is clear, else zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, r_dir} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_FWD;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DIRECTION)) begin
            r_dir <= pwdata[0];
        end
    end

    // Each stage loads when it is empty or its successor moves on.
    always_comb begin
        adv[PIPE_STAGES] = !r_vld[PIPE_STAGES] || o_res.ready;
        for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_pix.ready = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= PIPE_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 1) ? i_pix.valid : r_vld[k-1];
                end
            end
        end
    end

    hsvc_front u_front (
        .i_clk    (i_clk),
        .i_adv    (adv[1]),
        .i_dir    (r_dir),
        .i_red    (i_pix.red_in),
        .i_green  (i_pix.green_in),
        .i_blue   (i_pix.blue_in),
        .i_hue    (i_pix.hue_in),
        .i_sat    (i_pix.sat_in),
        .i_val    (i_pix.val_in),
        .i_no_hue (i_pix.no_hue_in),
        .o_front  (front)
    );

    hsvc_div_pipe u_div_sat (
        .i_clk (i_clk),
        .i_adv (adv[DIV_STAGES+1:2]),
        .i_num (front.sat_num),
        .i_den (front.mx),
        .o_quo (q_sat)
    );

    hsvc_div_pipe u_div_hue (
        .i_clk (i_clk),
        .i_adv (adv[DIV_STAGES+1:2]),
        .i_num (front.hue_num),
        .i_den (front.d),
        .o_quo (q_hue)
    );

    hsvc_inv_pipe u_inv (
        .i_clk   (i_clk),
        .i_adv   (adv[DIV_STAGES+1:2]),
        .i_s     (front.s),
        .i_v     (front.v),
        .i_x     (front.x),
        .i_sec   (front.sec),
        .i_grey  (front.grey),
        .o_red   (inv_r),
        .o_green (inv_g),
        .o_blue  (inv_b)
    );

    // Mode, hue-sector bits and the finished value ride alongside the divider stages.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (adv[k+2]) begin
                if (k == 0) begin
                    r_side[k] <= '{dir: front.dir, sect: front.sect, neg: front.neg,
                                   no_hue: front.no_hue, sat_zero: front.sat_zero,
                                   val: front.val_q};
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // Hue: sector base plus or minus the offset, wrapped into one turn.
    always_comb begin
        side = r_side[DIV_STAGES-1];
        case (side.sect)
            SECT_GREEN: base = 16'(2 * SECTOR);
            SECT_BLUE:  base = 16'(4 * SECTOR);
            default:    base = 16'd0;
        endcase
        if (side.neg) begin
            tmp = base + TURN - 16'(q_hue[SEC_W-1:0]);
        end else begin
            tmp = base + 16'(q_hue[SEC_W-1:0]);
        end
        if (tmp >= TURN) begin
            tmp = tmp - TURN;
        end
    end

    logic [HUE_W-1:0]  r_hue;
    logic [UNIT_W-1:0] r_sat, r_val;
    logic              r_no_hue;
    logic [PIX_W-1:0]  r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (adv[PIPE_STAGES]) begin
            if (side.dir == DIR_FWD) begin
                r_hue    <= side.no_hue ? '0 : tmp[HUE_W-1:0];
                r_sat    <= side.sat_zero ? '0 : q_sat[UNIT_W-1:0];
                r_val    <= side.val;
                r_no_hue <= side.no_hue;
                r_red    <= '0;
                r_green  <= '0;
                r_blue   <= '0;
            end else begin
                r_hue    <= '0;
                r_sat    <= '0;
                r_val    <= '0;
                r_no_hue <= 1'b0;
                r_red    <= inv_r;
                r_green  <= inv_g;
                r_blue   <= inv_b;
            end
        end
    end

    assign o_res.valid      = r_vld[PIPE_STAGES];
    assign o_res.hue_out    = r_hue;
    assign o_res.sat_out    = r_sat;
    assign o_res.val_out    = r_val;
    assign o_res.no_hue_out = r_no_hue;
    assign o_res.red_out    = r_red;
    assign o_res.green_out  = r_green;
    assign o_res.blue_out   = r_blue;

endmodule

FILE: rtl/hsvc_checker.sv
// Port-level assertions for the color converter and their binding to the top level.
module hsvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [14:0] i_hue,
    input logic [16:0] i_sat,
    input logic        i_no_hue,
    input logic [7:0]  i_red
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hue) && $stable(i_red))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output register");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hue < 15'd23040)
        else $error("hue beyond a full turn");

    a_grey_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_no_hue |-> i_hue == 15'd0 && i_sat == 17'd0)
        else $error("undefined hue with nonzero hue or saturation");
endmodule

bind rgb_hsv_color_convert_unit hsvc_checker u_hsvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hue       (o_res.hue_out),
    .i_sat       (o_res.sat_out),
    .i_no_hue    (o_res.no_hue_out),
    .i_red       (o_res.red_out)
);
